// File: hw/rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the RGB to HSV converter
// Holds field widths, hue constants, the sector code and the classified item.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int ChanW = 8;
  localparam int HueW  = 15;

  // Both quotients come from restoring divisions that run in lockstep.
  // The hue quotient needs 12 bits, the saturation quotient fits in 8.
  localparam int RemW          = 20;
  localparam int QuotW         = 12;
  localparam int StepsPerStage = 2;
  localparam int NumStages     = QuotW / StepsPerStage;

  localparam logic [HueW-1:0]  HueSector = 15'd7680;
  localparam logic [HueW-1:0]  HueFull   = 15'd23040;
  localparam logic [QuotW-1:0] HueHalf   = 12'd3840;

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    SECTOR_RED   = 2'd0,
    SECTOR_GREEN = 2'd1,
    SECTOR_BLUE  = 2'd2
  } sector_t;

  // One pixel after classification, ready for the dividers.
  typedef struct packed {
    logic             gray;
    sector_t          sector;
    logic             neg;
    logic [ChanW-1:0] max_val;
    logic [ChanW-1:0] delta;
    logic [RemW-1:0]  sat_rem;
    logic [RemW-1:0]  hue_rem;
  } item_t;

endpackage

// File: hw/rtl/rhc_if.sv
// ----------------------------------------------------------------------------
// rhc_if: stream channels of the RGB to HSV converter
// One interface for the pixel input and one for the HSV result.
// ----------------------------------------------------------------------------
interface rhc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rhc_pkg::ChanW-1:0] red;
  logic [rhc_pkg::ChanW-1:0] green;
  logic [rhc_pkg::ChanW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhc_hsv_if;
  logic                      valid;
  logic                      ready;
  logic [rhc_pkg::HueW-1:0]  hue;
  logic [rhc_pkg::ChanW-1:0] saturation;
  logic [rhc_pkg::ChanW-1:0] brightness;
  logic                      is_gray;

  modport source (output valid, hue, saturation, brightness, is_gray, input ready);
  modport sink   (input valid, hue, saturation, brightness, is_gray, output ready);
endinterface

// File: hw/rtl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front: pixel intake and classification
// Finds max, min and sector, and forms both dividends, into one register.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic           clk,
  input  logic           rst,
  rhc_pix_if.sink        pixel,
  output rhc_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_ready
);

  logic [rhc_pkg::ChanW-1:0] r, g, b;
  logic [rhc_pkg::ChanW-1:0] mx, mn, dlt, op_a, op_b, abs_diff;
  rhc_pkg::sector_t          sector;
  rhc_pkg::item_t            cls;

  assign r = pixel.red;
  assign g = pixel.green;
  assign b = pixel.blue;

  always_comb begin
    // Red wins ties, then green.
    if (r >= g && r >= b) begin
      sector = rhc_pkg::SECTOR_RED;
      mx     = r;
      op_a   = g;
      op_b   = b;
    end else if (g >= b) begin
      sector = rhc_pkg::SECTOR_GREEN;
      mx     = g;
      op_a   = b;
      op_b   = r;
    end else begin
      sector = rhc_pkg::SECTOR_BLUE;
      mx     = b;
      op_a   = r;
      op_b   = g;
    end
    mn       = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
    dlt      = mx - mn;
    abs_diff = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

    cls.gray    = (dlt == '0);
    cls.sector  = sector;
    cls.neg     = (op_a < op_b);
    cls.max_val = mx;
    cls.delta   = dlt;
    // 255 * delta and 3840 * |diff| as shifts and subtracts.
    cls.sat_rem = (rhc_pkg::RemW'(dlt) << 8) - rhc_pkg::RemW'(dlt);
    cls.hue_rem = (rhc_pkg::RemW'(abs_diff) << 12) - (rhc_pkg::RemW'(abs_diff) << 8);
  end

  assign pixel.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (pixel.ready) begin
      item_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.ready && pixel.valid) begin
      item <= cls;
    end
  end

endmodule

// File: hw/rtl/rhc_queue.sv
// ----------------------------------------------------------------------------
// rhc_queue: short queue between classification and division
// A small register FIFO so that intake and the divider pipeline stall apart.
// ----------------------------------------------------------------------------
module rhc_queue (
  input  logic           clk,
  input  logic           rst,
  input  rhc_pkg::item_t push_item,
  input  logic           push_valid,
  output logic           push_ready,
  output rhc_pkg::item_t pop_item,
  output logic           pop_valid,
  input  logic           pop_ready
);

  localparam int PtrW = (rhc_pkg::QueueDepth > 1) ? $clog2(rhc_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(rhc_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(rhc_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(rhc_pkg::QueueDepth);

  rhc_pkg::item_t  entries [rhc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push, pop;

  assign push_ready = (count != FullCnt);
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// File: hw/rtl/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back: divider pipeline and result register
// Two restoring divisions in lockstep, two quotient bits per stage.
// ----------------------------------------------------------------------------
module rhc_back (
  input  logic           clk,
  input  logic           rst,
  input  rhc_pkg::item_t in_item,
  input  logic           in_valid,
  output logic           in_ready,
  rhc_hsv_if.source      result
);

  localparam int Last = rhc_pkg::NumStages - 1;

  typedef struct packed {
    rhc_pkg::item_t                item;
    logic [rhc_pkg::QuotW-1:0]     q_sat;
    logic [rhc_pkg::QuotW-1:0]     q_hue;
  } stage_t;

  stage_t                       pipe      [rhc_pkg::NumStages];
  stage_t                       pipe_next [rhc_pkg::NumStages];
  logic [rhc_pkg::NumStages-1:0] pipe_valid;
  logic                         adv;
  logic [rhc_pkg::HueW-1:0]     hue_next;
  logic [rhc_pkg::HueW-1:0]     offset;
  logic [rhc_pkg::HueW-1:0]     q_ext;

  // One quotient bit of each division: the remainders are reduced in place.
  function automatic stage_t div_step(stage_t x, int k);
    stage_t                  y;
    logic [rhc_pkg::RemW-1:0] ds;
    logic [rhc_pkg::RemW-1:0] dh;
    y  = x;
    ds = rhc_pkg::RemW'(x.item.max_val) << k;
    dh = rhc_pkg::RemW'(x.item.delta) << k;
    if (x.item.sat_rem >= ds) begin
      y.item.sat_rem = x.item.sat_rem - ds;
      y.q_sat        = x.q_sat | (rhc_pkg::QuotW'(1) << k);
    end
    if (x.item.hue_rem >= dh) begin
      y.item.hue_rem = x.item.hue_rem - dh;
      y.q_hue        = x.q_hue | (rhc_pkg::QuotW'(1) << k);
    end
    return y;
  endfunction

  // The whole pipeline moves together whenever the result register is free.
  assign adv      = !result.valid || result.ready;
  assign in_ready = adv;

  always_comb begin
    stage_t cur;
    for (int s = 0; s < rhc_pkg::NumStages; s++) begin
      if (s == 0) begin
        cur.item  = in_item;
        cur.q_sat = '0;
        cur.q_hue = '0;
      end else begin
        cur = pipe[s-1];
      end
      for (int t = 0; t < rhc_pkg::StepsPerStage; t++) begin
        cur = div_step(cur, rhc_pkg::QuotW - 1 - (s * rhc_pkg::StepsPerStage + t));
      end
      pipe_next[s] = cur;
    end
  end

  always_comb begin
    q_ext = rhc_pkg::HueW'(pipe[Last].q_hue);
    case (pipe[Last].item.sector)
      rhc_pkg::SECTOR_RED:   offset = '0;
      rhc_pkg::SECTOR_GREEN: offset = rhc_pkg::HueSector;
      rhc_pkg::SECTOR_BLUE:  offset = rhc_pkg::HueSector << 1;
      default:               offset = '0;
    endcase
    if (!pipe[Last].item.neg) begin
      hue_next = offset + q_ext;
    end else if (pipe[Last].item.sector == rhc_pkg::SECTOR_RED && q_ext != '0) begin
      hue_next = rhc_pkg::HueFull - q_ext;
    end else begin
      hue_next = offset - q_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid   <= '0;
      result.valid <= 1'b0;
    end else if (adv) begin
      pipe_valid   <= {pipe_valid[rhc_pkg::NumStages-2:0], in_valid};
      result.valid <= pipe_valid[Last];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < rhc_pkg::NumStages; s++) begin
        pipe[s] <= pipe_next[s];
      end
      result.brightness <= pipe[Last].item.max_val;
      result.is_gray    <= pipe[Last].item.gray;
      if (pipe[Last].item.gray) begin
        result.hue        <= '0;
        result.saturation <= '0;
      end else begin
        result.hue        <= hue_next;
        result.saturation <= pipe[Last].q_sat[rhc_pkg::ChanW-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_sat_fits: assert property (@(posedge clk) disable iff (rst)
    pipe_valid[Last] && !pipe[Last].item.gray |->
      pipe[Last].q_sat[rhc_pkg::QuotW-1:rhc_pkg::ChanW] == '0)
    else $error("saturation quotient exceeds eight bits");

  a_hue_quot_bound: assert property (@(posedge clk) disable iff (rst)
    pipe_valid[Last] && !pipe[Last].item.gray |-> pipe[Last].q_hue <= rhc_pkg::HueHalf)
    else $error("hue quotient above one half sector");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.hue < rhc_pkg::HueFull)
    else $error("hue out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(pipe_valid))
    else $error("pipeline moved while the result was stalled");
`endif

endmodule

// File: hw/rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: streaming RGB to HSV conversion
// An accepted pixel beat passes the intake register, the queue, six divider
//   stages and the result register before its result beat.
// Throughput is one pixel per cycle while results are taken, set by the
//   divider pipeline that yields two quotient bits of both divisions per stage.
// Reset clears only valid bits and queue pointers and count, not payload.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic      clk,
  input  logic      rst,
  rhc_pix_if.sink   pixel,
  rhc_hsv_if.source result
);

  // The front register finds the largest and smallest channel, picks the hue
  // sector (red wins ties, then green), and forms the two dividends:
  // 255 * delta over the maximum for saturation, and 3840 * |difference| over
  // delta for the hue fraction.
  rhc_pkg::item_t front_item;
  logic           front_valid;
  logic           front_ready;

  // The queue lets the intake keep taking beats while the result side is
  // stalled, until its two entries are full, and vice versa.
  rhc_pkg::item_t queue_item;
  logic           queue_valid;
  logic           queue_ready;

  rhc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  rhc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (queue_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  // The back part runs both restoring divisions side by side, then adds the
  // sector offset, wraps a negative red-sector hue by a full turn, and
  // forces hue and saturation to zero for a gray pixel.
  rhc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_item  (queue_item),
    .in_valid (queue_valid),
    .in_ready (queue_ready),
    .result   (result)
  );

endmodule

// File: tb/sv/hsv_result_checker.sv
// ----------------------------------------------------------------------------
// hsv_result_checker: result prediction and comparison for the HSV converter
// Watches both channels. It predicts hue, saturation, value and the gray flag
// of every accepted pixel and compares each result beat with the oldest one.
// ----------------------------------------------------------------------------
module hsv_result_checker (
  input  logic clk,
  input  logic rst,
  rhc_pix_if   pixel,
  rhc_hsv_if   result,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   gray_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPrinted = 25;

  typedef struct packed {
    logic [rhc_pkg::HueW-1:0]  hue;
    logic [rhc_pkg::ChanW-1:0] saturation;
    logic [rhc_pkg::ChanW-1:0] brightness;
    logic                      is_gray;
  } hsv_t;

  hsv_t expected_hsv[$];

  // Integer arithmetic throughout, so the hue division truncates toward zero.
  function automatic hsv_t predict_hsv(logic [rhc_pkg::ChanW-1:0] r,
                                       logic [rhc_pkg::ChanW-1:0] g,
                                       logic [rhc_pkg::ChanW-1:0] b);
    int               rr, gg, bb, hi_chan, lo_chan, spread;
    int               sector_len, half_len, full_turn, base, slope, angle, sat_q;
    rhc_pkg::sector_t sect;
    hsv_t             res;
    rr = int'(r);
    gg = int'(g);
    bb = int'(b);
    sector_len = int'(rhc_pkg::HueSector);
    half_len   = int'(rhc_pkg::HueHalf);
    full_turn  = int'(rhc_pkg::HueFull);
    hi_chan = (rr > gg) ? rr : gg;
    hi_chan = (hi_chan > bb) ? hi_chan : bb;
    lo_chan = (rr < gg) ? rr : gg;
    lo_chan = (lo_chan < bb) ? lo_chan : bb;
    spread  = hi_chan - lo_chan;
    res.brightness = hi_chan[rhc_pkg::ChanW-1:0];
    if (spread == 0) begin
      res.hue        = '0;
      res.saturation = '0;
      res.is_gray    = 1'b1;
      return res;
    end
    // Red wins a tie for the maximum, then green.
    if (rr == hi_chan) sect = rhc_pkg::SECTOR_RED;
    else if (gg == hi_chan) sect = rhc_pkg::SECTOR_GREEN;
    else sect = rhc_pkg::SECTOR_BLUE;
    case (sect)
      rhc_pkg::SECTOR_RED: begin
        base  = 0;
        slope = gg - bb;
      end
      rhc_pkg::SECTOR_GREEN: begin
        base  = sector_len;
        slope = bb - rr;
      end
      default: begin
        base  = 2 * sector_len;
        slope = rr - gg;
      end
    endcase
    angle = base + (half_len * slope) / spread;
    if (angle < 0) angle = angle + full_turn;
    sat_q = (255 * spread) / hi_chan;
    res.hue        = angle[rhc_pkg::HueW-1:0];
    res.saturation = sat_q[rhc_pkg::ChanW-1:0];
    res.is_gray    = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    errors = errors + 1;
    if (errors <= MaxPrinted) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    hsv_t got, want;
    if (!rst) begin
      if (pixel.valid && pixel.ready)
        expected_hsv.push_back(predict_hsv(pixel.red, pixel.green, pixel.blue));
      if (result.valid && result.ready) begin
        got = {result.hue, result.saturation, result.brightness, result.is_gray};
        if (expected_hsv.size() == 0) begin
          report_mismatch($sformatf("result beat with no pixel waiting, hue %0d", got.hue));
        end else begin
          want = expected_hsv.pop_front();
          checked = checked + 1;
          if (want.is_gray) gray_count = gray_count + 1;
          if (got.hue !== want.hue)
            report_mismatch($sformatf("hue %0d, expected %0d", got.hue, want.hue));
          if (got.saturation !== want.saturation)
            report_mismatch($sformatf("saturation %0d, expected %0d",
                                      got.saturation, want.saturation));
          if (got.brightness !== want.brightness)
            report_mismatch($sformatf("brightness %0d, expected %0d",
                                      got.brightness, want.brightness));
          if (got.is_gray !== want.is_gray)
            report_mismatch($sformatf("is_gray %b, expected %b", got.is_gray, want.is_gray));
        end
      end
      pending <= expected_hsv.size();
    end
  end

endmodule

// File: tb/sv/tb_rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter: stream test of the RGB to HSV converter
// Drives corner pixels and then random pixels under four pacing phases on
// both channels. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no beat on either channel before the run is declared hung.
  // A correct run never comes close: idle and stall streaks end at random
  // and are vanishingly unlikely to get near it.
  localparam int QuietLimit   = 2000;
  // Hold-off after the last result before the final report.
  localparam int DrainCycles  = 20;
  localparam int RandPerPhase = 175;

  logic clk = 1'b0;
  logic rst;

  int idle_pct;
  int stall_pct;
  int directed_sent;
  int random_sent;
  int quiet_cycles;

  int errors;
  int pending;
  int checked;
  int gray_count;

  rhc_pix_if pix ();
  rhc_hsv_if hsv ();

  rgb_to_hsv_converter i_dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix),
    .result (hsv)
  );

  hsv_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pix),
    .result     (hsv),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .gray_count (gray_count)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver decides afresh at every falling edge whether it takes a
  // result beat, so stalls land on every phase of the divider pipeline.
  always @(negedge clk) begin
    hsv.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: any beat on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (hsv.valid && hsv.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("no beat for %0d cycles, %0d results outstanding", QuietLimit, pending);
      $display("tb_rgb_to_hsv_converter: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one pixel beat, with random idle cycles in front of it when the
  // current phase asks for them. It is entered and left at a falling edge,
  // so valid gets exactly one update in each time step.
  task automatic send_pixel(input logic [rhc_pkg::ChanW-1:0] r,
                            input logic [rhc_pkg::ChanW-1:0] g,
                            input logic [rhc_pkg::ChanW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
  endtask

  // Holds the input off until the block has delivered every result. The
  // first cycle is always spent idle so that valid is not dropped and raised
  // in the same step.
  task automatic wait_drained();
    pix.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Random pixel shapes. Plain uniform pixels dominate; the rest aim at the
  // gray case, ties for the maximum or minimum channel, and the channel
  // extremes where the hue wraps or the saturation saturates.
  task automatic make_pixel(output logic [rhc_pkg::ChanW-1:0] r,
                            output logic [rhc_pkg::ChanW-1:0] g,
                            output logic [rhc_pkg::ChanW-1:0] b);
    int                        kind, hi_v, lo_v;
    logic [rhc_pkg::ChanW-1:0] hv, lv;
    kind = $urandom_range(99);
    r = rhc_pkg::ChanW'($urandom_range(255));
    g = rhc_pkg::ChanW'($urandom_range(255));
    b = rhc_pkg::ChanW'($urandom_range(255));
    if (kind >= 60 && kind < 72) begin
      g = r;
      b = r;
    end else if (kind >= 72 && kind < 86) begin
      hi_v = $urandom_range(255, 1);
      lo_v = $urandom_range(hi_v - 1);
      hv   = rhc_pkg::ChanW'(hi_v);
      lv   = rhc_pkg::ChanW'(lo_v);
      case ($urandom_range(5))
        0: begin r = hv; g = hv; b = lv; end
        1: begin r = lv; g = hv; b = hv; end
        2: begin r = hv; g = lv; b = hv; end
        3: begin r = hv; g = lv; b = lv; end
        4: begin r = lv; g = hv; b = lv; end
        default: begin r = lv; g = lv; b = hv; end
      endcase
    end else if (kind >= 86) begin
      case ($urandom_range(4))
        0: r = 8'd0;
        1: r = 8'd1;
        2: r = 8'd254;
        3: r = 8'd255;
        default: ;
      endcase
      case ($urandom_range(4))
        0: g = 8'd0;
        1: g = 8'd1;
        2: g = 8'd254;
        3: g = 8'd255;
        default: ;
      endcase
      case ($urandom_range(4))
        0: b = 8'd0;
        1: b = 8'd1;
        2: b = 8'd254;
        3: b = 8'd255;
        default: ;
      endcase
    end
  endtask

  initial begin
    logic [rhc_pkg::ChanW-1:0] r, g, b;
    int phase, n;

    rst          = 1'b1;
    idle_pct     = 0;
    stall_pct    = 0;
    pix.valid    = 1'b0;
    pix.red      = '0;
    pix.green    = '0;
    pix.blue     = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pixels, sent back to back with the receiver always ready.
    // Gray pixels: black, white, mid gray and the smallest nonzero gray.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    // Primaries, one for each hue sector.
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    // Ties for the maximum: red beats green and blue, green beats blue.
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    // Red sector around zero: a negative hue (blue above green) wraps.
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd255, 8'd1, 8'd0);
    // Smallest colored pixels: delta equal to the maximum of one.
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    // Delta of one at the top of the range gives the smallest saturation.
    send_pixel(8'd254, 8'd255, 8'd254);
    send_pixel(8'd254, 8'd254, 8'd255);
    // Ordinary mixed colors in the red, blue and green sectors.
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd50, 8'd100, 8'd200);
    send_pixel(8'd100, 8'd200, 8'd50);
    directed_sent = 21;

    // Random pixels in four pacing phases: free flowing, idle sender,
    // stalling receiver, and both at a light rate. Each phase starts with
    // the pipeline drained, and now and then the sender drains it again.
    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      for (n = 0; n < RandPerPhase; n++) begin
        if ($urandom_range(99) == 0) wait_drained();
        make_pixel(r, g, b);
        send_pixel(r, g, b);
        random_sent = random_sent + 1;
      end
    end

    // Wait for every outstanding result, then a little longer to catch
    // any stray beat.
    pix.valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Sent %0d directed and %0d random pixels under four pacing phases.",
             directed_sent, random_sent);
    $display("Checked %0d results, %0d of them gray; %0d mismatches, %0d missing.",
             checked, gray_count, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("tb_rgb_to_hsv_converter: clean");
    end else begin
      $display("tb_rgb_to_hsv_converter: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/rhc_pkg.sv
hw/rtl/rhc_if.sv
hw/rtl/rhc_front.sv
hw/rtl/rhc_queue.sv
hw/rtl/rhc_back.sv
hw/rtl/rgb_to_hsv_converter.sv
tb/sv/hsv_result_checker.sv
tb/sv/tb_rgb_to_hsv_converter.sv
